### hdl/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off during reset.
`define TCPU_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tcpu: assertion failed");

// Next-cycle implication, off during reset.
`define TCPU_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tcpu: assertion failed");

`endif

### hdl/tcpu_pkg.sv
package tcpu_pkg;

    localparam int MEM_WORDS_DEF = 256;
    localparam int NUM_REGS_DEF  = 8;
    localparam int SLICE_LEN_DEF = 3;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 9;

    localparam logic [CFG_IDX_W-1:0] CFG_SEGMENT_BASE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SEGMENT_SIZE = 1'b1;

    localparam logic [1:0] FUNC_MEM_WRITE = 2'd0;
    localparam logic [1:0] FUNC_REG_WRITE = 2'd1;
    localparam logic [1:0] FUNC_EXECUTE   = 2'd2;

    localparam logic [3:0] REG_PC  = 4'd8;
    localparam logic [3:0] REG_ACC = 4'd9;

    localparam logic [2:0] IRQ_NONE    = 3'd0;
    localparam logic [2:0] IRQ_CLOCK   = 3'd1;
    localparam logic [2:0] IRQ_SEGV    = 3'd2;
    localparam logic [2:0] IRQ_SYSC    = 3'd3;
    localparam logic [2:0] IRQ_UNKNOWN = 3'd4;

    localparam logic [9:0] OP_ADD   = 10'd0;
    localparam logic [9:0] OP_SUB   = 10'd1;
    localparam logic [9:0] OP_CMP   = 10'd2;
    localparam logic [9:0] OP_IFGT  = 10'd3;
    localparam logic [9:0] OP_NOP   = 10'd4;
    localparam logic [9:0] OP_JUMP  = 10'd5;
    localparam logic [9:0] OP_HALT  = 10'd6;
    localparam logic [9:0] OP_SYSC  = 10'd7;
    localparam logic [9:0] OP_LOAD  = 10'd8;
    localparam logic [9:0] OP_STORE = 10'd9;

    typedef struct packed {
        logic [1:0]         func;
        logic [7:0]         mem_addr;
        logic [3:0]         reg_index;
        logic signed [31:0] write_data;
    } t_in_item;

    typedef struct packed {
        logic [2:0]         interrupt;
        logic signed [31:0] pc;
        logic signed [31:0] acc;
    } t_out_item;

endpackage

### hdl/teaching_cpu_instruction_step_top.sv
// Small segmented teaching CPU. Each item writes a memory word, writes a
// processor register (data register, PC or AC), or runs one instruction, and
// gives one result: interrupt code, PC and AC after the item. An input
// register takes the next item while the current one runs or its result waits.
// Write items finish in the idle state. An instruction runs fetch (ending
// there when the fetch faults), decode, operand and execute: instruction fetch
// from the word memory, register-file read, operand add, then execute with
// the data access; LOAD adds the memory read. Instruction memory is not
// cleared at reset and reads of unwritten words are undefined; data registers
// reset to zero through per-entry valid bits, so there is no clearing pass.
module teaching_cpu_instruction_step_top #(
    parameter int MEM_WORDS = tcpu_pkg::MEM_WORDS_DEF,
    parameter int NUM_REGS  = tcpu_pkg::NUM_REGS_DEF,
    parameter int SLICE_LEN = tcpu_pkg::SLICE_LEN_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [tcpu_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [tcpu_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  tcpu_pkg::t_in_item             i_in_item,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output tcpu_pkg::t_out_item            o_out_item
);

    localparam int MEM_AW = $clog2(MEM_WORDS);
    localparam int REG_AW = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
    localparam int SLC_W  = $clog2(SLICE_LEN + 1);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_DECODE = 5'b00010,
        ST_OPER   = 5'b00100,
        ST_EXEC   = 5'b01000,
        ST_LOAD   = 5'b10000
    } t_state;

    t_state              r_state, n_state;
    logic                r_in_valid;
    tcpu_pkg::t_in_item  r_in;
    logic                r_out_valid, n_out_valid;
    tcpu_pkg::t_out_item r_out, n_out;
    logic [31:0]         r_pc, n_pc;
    logic [31:0]         r_acc, n_acc;
    logic [SLC_W-1:0]    r_slice, n_slice;
    logic [7:0]          r_base;
    logic [8:0]          r_size;

    logic [31:0]         mem [MEM_WORDS];
    logic [31:0]         r_mem_q;
    logic                mem_we, mem_re;
    logic [MEM_AW-1:0]   mem_wa, mem_ra;
    logic [31:0]         mem_wd;

    logic [31:0]         rf [NUM_REGS];
    logic [NUM_REGS-1:0] r_rf_vld;
    logic [31:0]         r_rdi, r_rdj;
    logic                r_ok_i, r_ok_j;
    logic                rf_we, rf_re;
    logic [REG_AW-1:0]   rf_wa;
    logic [31:0]         rf_wd;

    logic [31:0]         r_word;
    logic [31:0]         r_vi, r_sum;

    logic                take, fin, done_ok;
    logic [2:0]          irq;
    logic [SLC_W-1:0]    slc_inc;
    logic [9:0]          w_op;
    logic [2:0]          w_ri, q_ri, q_rj;
    logic [31:0]         w_arg, t_res;
    logic                w_ri_ok;

    function automatic logic [MEM_AW-1:0] f_wrap(input logic [9:0] v);
        logic [9:0] r;
        r = v;
        for (int b = 5; b >= 0; b--) begin
            if ({22'd0, r} >= (32'(MEM_WORDS) << b)) begin
                r = r - 10'(32'(MEM_WORDS) << b);
            end
        end
        return MEM_AW'(r);
    endfunction

    function automatic logic f_in_seg(input logic [31:0] off, input logic [8:0] size);
        return (off[31:9] == 23'd0) && (off[8:0] < size);
    endfunction

    function automatic logic [MEM_AW-1:0] f_phys(input logic [31:0] off,
                                                  input logic [7:0] base);
        return f_wrap({2'b00, base} + {1'b0, off[8:0]});
    endfunction

    assign take       = r_in_valid && (r_state == ST_IDLE) && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || take;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    assign w_op    = r_word[9:0];
    assign w_ri    = r_word[12:10];
    assign w_arg   = {{16{r_word[31]}}, r_word[31:16]};
    assign w_ri_ok = ({1'b0, w_ri} < 4'(NUM_REGS));
    assign q_ri    = r_mem_q[12:10];
    assign q_rj    = r_mem_q[15:13];
    assign slc_inc = r_slice + SLC_W'(1);

    always_comb begin
        n_state = r_state;
        n_pc    = r_pc;
        n_acc   = r_acc;
        n_slice = r_slice;
        irq     = tcpu_pkg::IRQ_NONE;
        fin     = 1'b0;
        done_ok = 1'b0;
        t_res   = '0;
        mem_we  = 1'b0;
        mem_wa  = '0;
        mem_wd  = '0;
        mem_re  = 1'b0;
        mem_ra  = '0;
        rf_we   = 1'b0;
        rf_wa   = '0;
        rf_wd   = '0;
        rf_re   = 1'b0;

        case (r_state)
            ST_IDLE: begin
                if (take) begin
                    case (r_in.func)
                        tcpu_pkg::FUNC_MEM_WRITE: begin
                            mem_we = 1'b1;
                            mem_wa = f_wrap({2'b00, r_in.mem_addr});
                            mem_wd = r_in.write_data;
                            fin    = 1'b1;
                        end
                        tcpu_pkg::FUNC_REG_WRITE: begin
                            if (r_in.reg_index < tcpu_pkg::REG_PC) begin
                                rf_we = (r_in.reg_index < 4'(NUM_REGS));
                                rf_wa = r_in.reg_index[REG_AW-1:0];
                                rf_wd = r_in.write_data;
                            end else if (r_in.reg_index == tcpu_pkg::REG_PC) begin
                                n_pc = r_in.write_data;
                            end else if (r_in.reg_index == tcpu_pkg::REG_ACC) begin
                                n_acc = r_in.write_data;
                            end
                            fin = 1'b1;
                        end
                        tcpu_pkg::FUNC_EXECUTE: begin
                            if (f_in_seg(r_pc, r_size)) begin
                                mem_re  = 1'b1;
                                mem_ra  = f_phys(r_pc, r_base);
                                n_state = ST_DECODE;
                            end else begin
                                irq = tcpu_pkg::IRQ_SEGV;
                                fin = 1'b1;
                            end
                        end
                        default: begin
                            fin = 1'b1;
                        end
                    endcase
                end
            end
            ST_DECODE: begin
                rf_re   = 1'b1;
                n_state = ST_OPER;
            end
            ST_OPER: begin
                n_state = ST_EXEC;
            end
            ST_EXEC: begin
                fin = 1'b1;
                case (w_op)
                    tcpu_pkg::OP_ADD, tcpu_pkg::OP_SUB: begin
                        t_res   = (w_op == tcpu_pkg::OP_ADD) ? r_vi + r_sum : r_vi - r_sum;
                        rf_we   = w_ri_ok;
                        rf_wa   = w_ri[REG_AW-1:0];
                        rf_wd   = t_res;
                        n_acc   = t_res;
                        n_pc    = r_pc + 32'd1;
                        done_ok = 1'b1;
                    end
                    tcpu_pkg::OP_CMP: begin
                        n_acc   = r_vi - r_sum;
                        n_pc    = r_pc + 32'd1;
                        done_ok = 1'b1;
                    end
                    tcpu_pkg::OP_IFGT: begin
                        n_pc    = (!r_acc[31] && (r_acc != 32'd0)) ? w_arg : r_pc + 32'd1;
                        done_ok = 1'b1;
                    end
                    tcpu_pkg::OP_NOP, tcpu_pkg::OP_HALT: begin
                        n_pc    = r_pc + 32'd1;
                        done_ok = 1'b1;
                    end
                    tcpu_pkg::OP_JUMP: begin
                        n_pc    = w_arg;
                        done_ok = 1'b1;
                    end
                    tcpu_pkg::OP_SYSC: begin
                        n_pc = r_pc + 32'd1;
                        irq  = tcpu_pkg::IRQ_SYSC;
                    end
                    tcpu_pkg::OP_LOAD: begin
                        n_acc = r_sum;
                        if (f_in_seg(r_sum, r_size)) begin
                            mem_re  = 1'b1;
                            mem_ra  = f_phys(r_sum, r_base);
                            fin     = 1'b0;
                            n_state = ST_LOAD;
                        end else begin
                            irq = tcpu_pkg::IRQ_SEGV;
                        end
                    end
                    tcpu_pkg::OP_STORE: begin
                        n_acc = r_sum;
                        if (f_in_seg(r_sum, r_size)) begin
                            mem_we  = 1'b1;
                            mem_wa  = f_phys(r_sum, r_base);
                            mem_wd  = r_vi;
                            n_acc   = r_vi;
                            n_pc    = r_pc + 32'd1;
                            done_ok = 1'b1;
                        end else begin
                            irq = tcpu_pkg::IRQ_SEGV;
                        end
                    end
                    default: begin
                        irq = tcpu_pkg::IRQ_UNKNOWN;
                    end
                endcase
            end
            ST_LOAD: begin
                rf_we   = w_ri_ok;
                rf_wa   = w_ri[REG_AW-1:0];
                rf_wd   = r_mem_q;
                n_acc   = r_mem_q;
                n_pc    = r_pc + 32'd1;
                done_ok = 1'b1;
                fin     = 1'b1;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        if (done_ok) begin
            if (slc_inc >= SLC_W'(SLICE_LEN)) begin
                irq     = tcpu_pkg::IRQ_CLOCK;
                n_slice = '0;
            end else begin
                n_slice = slc_inc;
            end
        end else if (irq != tcpu_pkg::IRQ_NONE) begin
            n_slice = '0;
        end

        if (fin) begin
            n_state = ST_IDLE;
        end

        n_out_valid     = r_out_valid && !i_out_ready;
        n_out.interrupt = irq;
        n_out.pc        = n_pc;
        n_out.acc       = n_acc;
        if (fin) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_pc        <= '0;
            r_acc       <= '0;
            r_slice     <= '0;
            r_base      <= '0;
            r_size      <= 9'd256;
            r_rf_vld    <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_pc        <= n_pc;
            r_acc       <= n_acc;
            r_slice     <= n_slice;
            if (i_in_valid && o_in_ready) begin
                r_in_valid <= 1'b1;
            end else if (take) begin
                r_in_valid <= 1'b0;
            end
            if (rf_we) begin
                r_rf_vld[rf_wa] <= 1'b1;
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    tcpu_pkg::CFG_SEGMENT_BASE: r_base <= i_cfg_wdata[7:0];
                    tcpu_pkg::CFG_SEGMENT_SIZE: r_size <= i_cfg_wdata;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in <= i_in_item;
        end
        if (fin) begin
            r_out <= n_out;
        end
        if (r_state == ST_DECODE) begin
            r_word <= r_mem_q;
        end
        if (r_state == ST_OPER) begin
            r_vi  <= r_ok_i ? r_rdi : 32'd0;
            r_sum <= (r_ok_j ? r_rdj : 32'd0) + w_arg;
        end
    end

    // word memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            r_mem_q <= mem[mem_ra];
        end
    end

    // data registers: one write port, two registered read ports
    always_ff @(posedge i_clk) begin
        if (rf_we) begin
            rf[rf_wa] <= rf_wd;
        end
        if (rf_re) begin
            r_rdi  <= rf[q_ri[REG_AW-1:0]];
            r_rdj  <= rf[q_rj[REG_AW-1:0]];
            r_ok_i <= ({1'b0, q_ri} < 4'(NUM_REGS)) && r_rf_vld[q_ri[REG_AW-1:0]];
            r_ok_j <= ({1'b0, q_rj} < 4'(NUM_REGS)) && r_rf_vld[q_rj[REG_AW-1:0]];
        end
    end

endmodule

### hdl/tcpu_checker.sv
`include "assert_macros.svh"

module tcpu_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_cfg_we,
    input logic [tcpu_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input logic [tcpu_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    input logic                           i_in_valid,
    input logic                           o_in_ready,
    input tcpu_pkg::t_in_item             i_in_item,
    input logic                           o_out_valid,
    input logic                           i_out_ready,
    input tcpu_pkg::t_out_item            o_out_item
);

    `TCPU_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid)

    `TCPU_ASSERT_NXT(a_out_stable, i_clk, i_rst_n, o_out_valid && !i_out_ready, $stable(o_out_item))

    // input buffer only fills through an accepted item
    `TCPU_ASSERT_IMP(a_ready_fall, i_clk, i_rst_n, $fell(o_in_ready), $past(i_in_valid && o_in_ready))

    `TCPU_ASSERT_IMP(a_irq_range, i_clk, i_rst_n, o_out_valid, o_out_item.interrupt <= tcpu_pkg::IRQ_UNKNOWN)

endmodule

bind teaching_cpu_instruction_step_top tcpu_checker u_tcpu_checker (.*);
